// ===== hdl/pcf_pkg.sv =====
// ============================================================================
// pcf_pkg: presence confidence fusion shared types and constants
// Field types, register indexes, reset values and sequencer codes used by the
// fusion datapath, its bit-serial multiplier and the channel interfaces.
// ============================================================================
`default_nettype none

package pcf_pkg;

   // Field types
   typedef logic [14:0] score_type;
   typedef logic [15:0] weight_type;
   typedef logic [16:0] composite_type;
   typedef logic [1:0]  band_type;
   typedef logic [3:0]  csr_index_type;

   // Multiplier operand is always a 16-bit weight, tilt or alpha
   localparam int MULT_W = 16;
   localparam int CNT_W  = $clog2(MULT_W);
   typedef logic [CNT_W-1:0] bit_cnt_type;
   localparam bit_cnt_type STEP_LAST = bit_cnt_type'(MULT_W - 1);

   // Saturation limit of the raw composite output
   localparam composite_type RAW_MAX = 17'h1FFFF;

   // Configuration register indexes
   localparam csr_index_type CSR_WEIGHT_RADAR   = 4'd0;
   localparam csr_index_type CSR_WEIGHT_DOPPLER = 4'd1;
   localparam csr_index_type CSR_WEIGHT_GAS     = 4'd2;
   localparam csr_index_type CSR_WEIGHT_SOUND   = 4'd3;
   localparam csr_index_type CSR_ALPHA          = 4'd4;
   localparam csr_index_type CSR_BAND_CONFIRMED = 4'd5;
   localparam csr_index_type CSR_BAND_PROBABLE  = 4'd6;
   localparam csr_index_type CSR_BAND_UNCERTAIN = 4'd7;

   // Configuration reset values
   localparam weight_type WEIGHT_RESET    = 16'd16384;
   localparam weight_type ALPHA_RESET     = 16'd19661;
   localparam score_type  CONFIRMED_RESET = 15'd20480;
   localparam score_type  PROBABLE_RESET  = 15'd12800;
   localparam score_type  UNCERTAIN_RESET = 15'd5120;

   // Band codes
   localparam band_type BAND_CLEAR     = 2'd0;
   localparam band_type BAND_UNCERTAIN = 2'd1;
   localparam band_type BAND_PROBABLE  = 2'd2;
   localparam band_type BAND_CONFIRMED = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_STEP,
      ST_POST,
      ST_DONE
   } state_type;

   // Product passes, in processing order
   typedef enum logic [2:0] {
      PASS_RADAR,
      PASS_DOPPLER,
      PASS_GAS,
      PASS_SOUND,
      PASS_TILT,
      PASS_BLEND
   } pass_type;

   // Multiplier control from the sequencer
   typedef struct packed {
      logic load;
      logic step;
   } mac_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/pcf_intf.sv =====
// ============================================================================
// pcf channel interfaces
// Valid/ready channels for sensor transactions, fusion results and
// configuration register writes.
// ============================================================================
`default_nettype none

interface pcf_req_if;
   logic                valid;
   logic                ready;
   pcf_pkg::score_type  radar_score;
   logic                doppler_trigger;
   pcf_pkg::score_type  gas_score;
   pcf_pkg::score_type  sound_score;
   pcf_pkg::weight_type tilt_weight;

   modport source (output valid, radar_score, doppler_trigger, gas_score, sound_score,
                   tilt_weight, input ready);
   modport sink (input valid, radar_score, doppler_trigger, gas_score, sound_score,
                 tilt_weight, output ready);
endinterface

interface pcf_rsp_if;
   logic                   valid;
   logic                   ready;
   pcf_pkg::composite_type raw_composite;
   pcf_pkg::score_type     confidence;
   pcf_pkg::band_type      band;

   modport source (output valid, raw_composite, confidence, band, input ready);
   modport sink (input valid, raw_composite, confidence, band, output ready);
endinterface

interface pcf_csr_if;
   logic                   valid;
   logic                   ready;
   pcf_pkg::csr_index_type index;
   logic [15:0]            data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pcf_serial_mac.sv =====
// ============================================================================
// pcf_serial_mac: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle, LSB first. Each step adds one of two
// addends, chosen by the current bit, and shifts the accumulator right, so
// after 16 steps the accumulator holds (init + sum) >> 16.
// ============================================================================
`default_nettype none

module pcf_serial_mac #(
   parameter int ACC_W = 18
) (
   input  logic                 clock,
   input  pcf_pkg::mac_ctl_type ctl,
   input  logic [ACC_W-1:0]     init_acc,
   input  pcf_pkg::weight_type  init_mult,
   input  logic [ACC_W-1:0]     init_add1,
   input  logic [ACC_W-1:0]     init_add0,
   output logic [ACC_W-1:0]     acc,
   output logic                 lo_bit
);
   import pcf_pkg::*;

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] add1_ff, add0_ff;
   weight_type       mult_ff, mult_in;
   logic             lo_ff, lo_in;
   logic [ACC_W:0]   sum;

   // One shift-add step
   always_comb begin
      sum     = {1'b0, acc_ff} + {1'b0, (mult_ff[0] ? add1_ff : add0_ff)};
      acc_in  = acc_ff;
      mult_in = mult_ff;
      lo_in   = lo_ff;
      if (ctl.load) begin
         acc_in  = init_acc;
         mult_in = init_mult;
      end else if (ctl.step) begin
         acc_in  = sum[ACC_W:1];
         mult_in = {1'b0, mult_ff[MULT_W-1:1]};
         lo_in   = sum[0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mult_ff <= mult_in;
      lo_ff   <= lo_in;
      if (ctl.load) begin
         add1_ff <= init_add1;
         add0_ff <= init_add0;
      end
   end

   assign acc    = acc_ff;
   assign lo_bit = lo_ff;

endmodule

`default_nettype wire

// ===== hdl/presence_confidence_fusion_top.sv =====
// One transaction at a time: a new one is taken only after the previous result has been
//   loaded into the result register; six products each sweep 16 multiplier bits
//   through the one bit-serial multiplier.
// Reset (synchronous, active high) restores the configuration defaults,
//   clears the smoothed confidence and drops any pending result.
// ============================================================================
// presence_confidence_fusion_top: sensor presence confidence fusion
// Weighted sum of radar, doppler, gas and sound scores, tilt scaling, IIR
// smoothing, clamping and banding, all products on one serial multiplier.
// ============================================================================
`default_nettype none

module presence_confidence_fusion_top #(
   parameter int FRAC_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   pcf_req_if.sink    req_chan,
   pcf_rsp_if.source  rsp_chan,
   pcf_csr_if.sink    csr_chan
);
   import pcf_pkg::*;

   // Widths that follow from the score format
   localparam int DopW      = FRAC_BITS + 7;
   localparam int ScoreMaxW = (DopW > 15) ? DopW : 15;
   localparam int CompW     = ScoreMaxW + 2;
   localparam int OrientW   = CompW + 1;
   localparam int FullInt   = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);

   localparam logic [DopW-1:0]    DopFull   = DopW'(100 << FRAC_BITS);
   localparam logic [OrientW-1:0] FullWide  = OrientW'(FullInt);
   localparam score_type          FullScore = 15'(FullInt);
   localparam logic [CompW-1:0]   RawMaxW   = CompW'(RAW_MAX);

   // Sequencer outputs
   typedef struct packed {
      logic        req_ready;
      mac_ctl_type mac;
      logic        post;
      logic        out_load;
   } fsm_out_type;

   state_type   state_ff, state_in;
   pass_type    pass_ff, pass_in;
   bit_cnt_type bit_cnt_ff, bit_cnt_in;
   fsm_out_type fsm;

   // Configuration registers
   weight_type w_radar_ff, w_dop_ff, w_gas_ff, w_sound_ff, alpha_ff;
   score_type  thr_conf_ff, thr_prob_ff, thr_unc_ff;

   // Captured transaction
   score_type  radar_ff, gas_ff, sound_ff;
   logic       dop_ff;
   weight_type tilt_ff;

   // Datapath state
   logic [CompW-1:0]   comp_ff, comp_in;
   logic [OrientW-1:0] orient_ff, orient_in;
   score_type          smooth_ff, smooth_in;

   // Multiplier connection
   logic [OrientW-1:0] mac_init_acc, mac_add1, mac_add0, mac_acc;
   weight_type         mac_mult;
   logic               mac_lo;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   composite_type rsp_raw_ff;
   score_type     rsp_conf_ff;
   band_type      rsp_band_ff;
   band_type      band_calc;
   logic          req_acc;

   assign req_acc = req_chan.valid && fsm.req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_chan.valid) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_STEP;
         ST_STEP: if (bit_cnt_ff == STEP_LAST) state_in = ST_POST;
         ST_POST: state_in = (pass_ff == PASS_BLEND) ? ST_DONE : ST_LOAD;
         ST_DONE: if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs; no transaction is taken while in reset
   always_comb begin
      fsm = '0;
      case (state_ff)
         ST_IDLE: fsm.req_ready = !reset;
         ST_LOAD: fsm.mac.load = 1'b1;
         ST_STEP: fsm.mac.step = 1'b1;
         ST_POST: fsm.post = 1'b1;
         ST_DONE: fsm.out_load = !rsp_valid_ff || rsp_chan.ready;
         default: fsm = '0;
      endcase
   end

   // Pass and bit counters
   always_comb begin
      pass_in    = pass_ff;
      bit_cnt_in = bit_cnt_ff;
      if (req_acc) begin
         pass_in = PASS_RADAR;
      end else if (fsm.post && pass_ff != PASS_BLEND) begin
         pass_in = pass_type'(pass_ff + 3'd1);
      end
      if (fsm.mac.load) begin
         bit_cnt_in = '0;
      end else if (fsm.mac.step) begin
         bit_cnt_in = bit_cnt_ff + bit_cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pass_ff    <= PASS_RADAR;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pass_ff    <= pass_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   // Configuration writes; indexes past the list are dropped
   assign csr_chan.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_radar_ff  <= WEIGHT_RESET;
         w_dop_ff    <= WEIGHT_RESET;
         w_gas_ff    <= WEIGHT_RESET;
         w_sound_ff  <= WEIGHT_RESET;
         alpha_ff    <= ALPHA_RESET;
         thr_conf_ff <= CONFIRMED_RESET;
         thr_prob_ff <= PROBABLE_RESET;
         thr_unc_ff  <= UNCERTAIN_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_WEIGHT_RADAR:   w_radar_ff  <= csr_chan.data;
            CSR_WEIGHT_DOPPLER: w_dop_ff    <= csr_chan.data;
            CSR_WEIGHT_GAS:     w_gas_ff    <= csr_chan.data;
            CSR_WEIGHT_SOUND:   w_sound_ff  <= csr_chan.data;
            CSR_ALPHA:          alpha_ff    <= csr_chan.data;
            CSR_BAND_CONFIRMED: thr_conf_ff <= csr_chan.data[14:0];
            CSR_BAND_PROBABLE:  thr_prob_ff <= csr_chan.data[14:0];
            CSR_BAND_UNCERTAIN: thr_unc_ff  <= csr_chan.data[14:0];
            default: ;
         endcase
      end
   end

   // Transaction capture
   always_ff @(posedge clock) begin
      if (req_acc) begin
         radar_ff <= req_chan.radar_score;
         dop_ff   <= req_chan.doppler_trigger;
         gas_ff   <= req_chan.gas_score;
         sound_ff <= req_chan.sound_score;
         tilt_ff  <= req_chan.tilt_weight;
      end
   end

   // Operand select per pass. The blend pass computes
   // s + sum(alpha_i ? orient : s) << i, i.e. s*(65536-alpha) + orient*alpha.
   always_comb begin
      mac_init_acc = '0;
      mac_add0     = '0;
      mac_add1     = '0;
      mac_mult     = '0;
      case (pass_ff)
         PASS_RADAR: begin
            mac_mult = w_radar_ff;
            mac_add1 = OrientW'(radar_ff);
         end
         PASS_DOPPLER: begin
            mac_mult = w_dop_ff;
            mac_add1 = dop_ff ? OrientW'(DopFull) : '0;
         end
         PASS_GAS: begin
            mac_mult = w_gas_ff;
            mac_add1 = OrientW'(gas_ff);
         end
         PASS_SOUND: begin
            mac_mult = w_sound_ff;
            mac_add1 = OrientW'(sound_ff);
         end
         PASS_TILT: begin
            mac_mult = tilt_ff;
            mac_add1 = OrientW'(comp_ff);
         end
         PASS_BLEND: begin
            mac_mult     = alpha_ff;
            mac_add1     = orient_ff;
            mac_add0     = OrientW'(smooth_ff);
            mac_init_acc = OrientW'(smooth_ff);
         end
         default: mac_mult = '0;
      endcase
   end

   pcf_serial_mac #(
      .ACC_W (OrientW)
   ) u_mac (
      .clock     (clock),
      .ctl       (fsm.mac),
      .init_acc  (mac_init_acc),
      .init_mult (mac_mult),
      .init_add1 (mac_add1),
      .init_add0 (mac_add0),
      .acc       (mac_acc),
      .lo_bit    (mac_lo)
   );

   // Fold each finished product into the datapath
   always_comb begin
      comp_in   = comp_ff;
      orient_in = orient_ff;
      smooth_in = smooth_ff;
      if (req_acc) begin
         comp_in = '0;
      end else if (fsm.post) begin
         case (pass_ff)
            PASS_TILT:  orient_in = {mac_acc[CompW-1:0], mac_lo};
            PASS_BLEND: smooth_in = (mac_acc > FullWide) ? FullScore : mac_acc[14:0];
            default:    comp_in   = comp_ff + mac_acc[CompW-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      comp_ff   <= comp_in;
      orient_ff <= orient_in;
      if (reset) begin
         smooth_ff <= '0;
      end else begin
         smooth_ff <= smooth_in;
      end
   end

   // Banding, confirmed first
   always_comb begin
      if (smooth_ff >= thr_conf_ff) begin
         band_calc = BAND_CONFIRMED;
      end else if (smooth_ff >= thr_prob_ff) begin
         band_calc = BAND_PROBABLE;
      end else if (smooth_ff >= thr_unc_ff) begin
         band_calc = BAND_UNCERTAIN;
      end else begin
         band_calc = BAND_CLEAR;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fsm.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fsm.out_load) begin
         rsp_raw_ff  <= (comp_ff > RawMaxW) ? RAW_MAX : comp_ff[16:0];
         rsp_conf_ff <= smooth_ff;
         rsp_band_ff <= band_calc;
      end
   end

   assign req_chan.ready         = fsm.req_ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.raw_composite = rsp_raw_ff;
   assign rsp_chan.confidence    = rsp_conf_ff;
   assign rsp_chan.band          = rsp_band_ff;

endmodule

`default_nettype wire

// ===== hdl/pcf_checker.sv =====
// ============================================================================
// pcf_checker: port-level checks for the fusion block
// Watches the request and result channels of the top level.
// ============================================================================
`default_nettype none

module pcf_checker #(
   parameter int FRAC_BITS = 8
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input pcf_pkg::composite_type rsp_raw,
   input pcf_pkg::score_type rsp_conf,
   input pcf_pkg::band_type  rsp_band
);
   import pcf_pkg::*;

   localparam int        FullInt   = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
   localparam score_type FullScore = 15'(FullInt);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_raw) && $stable(rsp_conf) && $stable(rsp_band))
      else $error("result payload changed while stalled");

   // Confidence never exceeds full scale
   a_conf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_conf <= FullScore)
      else $error("confidence above full scale");

   // One transaction in flight: the block goes busy after accepting
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");

   // Reset empties the result register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind presence_confidence_fusion_top pcf_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_pcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_raw   (rsp_chan.raw_composite),
   .rsp_conf  (rsp_chan.confidence),
   .rsp_band  (rsp_chan.band)
);

`default_nettype wire
